@@ src/assert_macros.svh @@
// Assertion macros used by the checker module evs_checker.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ src/evs_pkg.sv @@
// Package for the encoder velocity estimator: payload structs, register
// indexes, sequencer states and the fixed-point helpers. No dependencies.
package evs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SHIFT_Q    = 32 - FRAC_BITS;
  localparam int PROD_W     = 64;
  localparam int SCALED_W   = PROD_W + 10;
  localparam int NQ_W       = SCALED_W - SHIFT_Q;
  localparam int HI_W       = NQ_W - 32;
  localparam int GAIN_W     = 16;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET  = 16'd22938;
  localparam logic [SCALED_W-1:0] SPEED_SCALE = SCALED_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_RADIANS_PER_TICK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN      = 1'b1;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic        [31:0] time_ms;
  } evs_sample_t;

  typedef struct packed {
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
    logic        [31:0] elapsed_ms;
  } evs_result_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] quotient;
  } evs_div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_POS_L,
    ST_MUL_POS_R,
    ST_MUL_SPEED,
    ST_SCALE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RAW,
    ST_DIFF,
    ST_FMUL,
    ST_FUPD,
    ST_OUTPUT
  } evs_state_t;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Magnitude and sign to saturated two's complement.
  function automatic logic [31:0] sat_pack(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) r = 32'h8000_0000;
      else r = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/encoder_velocity_estimator_unit.sv @@
// Encoder velocity estimator: positions and filtered wheel speeds per sample.
// A new sample is taken only in the idle state, so the next sample waits until the
// result is out, and a stalled result holds the sequencer; each sample makes two
// passes (32 divider steps each) on the shared multiplier and divider.
// A sample with zero elapsed time is dropped in the transfer cycle.
// Synchronous active-high reset clears state, registers to defaults, no result.
module encoder_velocity_estimator_unit import evs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  evs_sample_t          sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output evs_result_t          result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  evs_state_t state, state_next;

  logic [31:0]       radians_per_tick;
  logic [GAIN_W-1:0] filter_gain;
  logic [31:0]       last_time, last_left, last_right;
  logic [31:0]       f_left, f_right;
  logic [31:0]       lc, rc, dt, dl, dr;
  logic              side;
  logic [PROD_W-1:0] prod;
  logic [SCALED_W-1:0] scaled;
  logic [31:0]       raw;
  logic [31:0]       diff_mag;
  logic              diff_neg;
  logic [31:0]       left_pos, right_pos;

  logic [31:0]       dt_in;
  logic              accept;
  logic              out_free;
  logic              mul_en;
  logic              div_start;
  logic [31:0]       mul_a, mul_b;
  logic [31:0]       f_sel;
  logic              speed_neg;
  logic [32:0]       d33, d33_neg;
  logic [31:0]       adj;
  logic [33:0]       nf;
  logic [31:0]       nf_sat;
  evs_div_res_t      div_res;

  assign dt_in    = sample.time_ms - last_time;
  assign accept   = sample_valid && !sample_stall;
  assign out_free = !result_valid || !result_stall;
  assign f_sel    = side ? f_right : f_left;
  // left side is reported negated
  assign speed_neg = side ? dr[31] : !dl[31];

  assign d33     = {raw[31], raw} - {f_sel[31], f_sel};
  assign d33_neg = ~d33 + 33'd1;
  assign adj     = prod[GAIN_W +: 32];
  assign nf      = diff_neg ? ({{2{f_sel[31]}}, f_sel} - {2'b00, adj})
                            : ({{2{f_sel[31]}}, f_sel} + {2'b00, adj});
  always_comb begin
    if (nf[33:31] == 3'b000 || nf[33:31] == 3'b111) nf_sat = nf[31:0];
    else if (nf[33]) nf_sat = 32'h8000_0000;
    else nf_sat = 32'h7FFF_FFFF;
  end

  evs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scaled[SCALED_W-1:SHIFT_Q]),
    .divisor  (dt),
    .res      (div_res)
  );

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (sample_valid && dt_in != 32'd0) state_next = ST_MUL_POS_L;
      ST_MUL_POS_L: state_next = ST_MUL_POS_R;
      ST_MUL_POS_R: state_next = ST_MUL_SPEED;
      ST_MUL_SPEED: state_next = ST_SCALE;
      ST_SCALE:     state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_res.done) state_next = ST_RAW;
      ST_RAW:       state_next = ST_DIFF;
      ST_DIFF:      state_next = ST_FMUL;
      ST_FMUL:      state_next = ST_FUPD;
      ST_FUPD:      state_next = side ? ST_OUTPUT : ST_MUL_SPEED;
      ST_OUTPUT:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    sample_stall = 1'b1;
    mul_en       = 1'b0;
    div_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    unique case (state)
      ST_IDLE:      sample_stall = 1'b0;
      ST_MUL_POS_L: begin
        mul_en = 1'b1;
        mul_a  = abs32(lc);
        mul_b  = radians_per_tick;
      end
      ST_MUL_POS_R: begin
        mul_en = 1'b1;
        mul_a  = abs32(rc);
        mul_b  = radians_per_tick;
      end
      ST_MUL_SPEED: begin
        mul_en = 1'b1;
        mul_a  = abs32(side ? dr : dl);
        mul_b  = radians_per_tick;
      end
      ST_DIV_START: div_start = 1'b1;
      ST_FMUL: begin
        mul_en = 1'b1;
        mul_a  = diff_mag;
        mul_b  = 32'(filter_gain);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radians_per_tick <= '0;
      filter_gain      <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIANS_PER_TICK: radians_per_tick <= cfg_data;
        REG_FILTER_GAIN:      filter_gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // persistent estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time  <= '0;
      last_left  <= '0;
      last_right <= '0;
      f_left     <= '0;
      f_right    <= '0;
      side       <= 1'b0;
    end else begin
      if (accept && dt_in != 32'd0) begin
        last_time  <= sample.time_ms;
        last_left  <= sample.left_count;
        last_right <= sample.right_count;
        side       <= 1'b0;
      end
      if (state == ST_FUPD) begin
        if (side) f_right <= nf_sat;
        else f_left <= nf_sat;
        side <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept && dt_in != 32'd0) begin
      lc <= sample.left_count;
      rc <= sample.right_count;
      dt <= dt_in;
      dl <= sample.left_count - last_left;
      dr <= sample.right_count - last_right;
    end
    if (mul_en) prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (state == ST_MUL_POS_R) left_pos <= sat_pack(prod >> SHIFT_Q, !lc[31]);
    if (state == ST_MUL_SPEED && !side) right_pos <= sat_pack(prod >> SHIFT_Q, rc[31]);
    if (state == ST_SCALE) scaled <= SCALED_W'(prod) * SPEED_SCALE;
    if (state == ST_RAW) begin
      raw <= sat_pack(div_res.sat ? 64'h0000_0000_FFFF_FFFF : 64'(div_res.quotient),
                      speed_neg);
    end
    if (state == ST_DIFF) begin
      diff_neg <= d33[32];
      diff_mag <= d33[32] ? d33_neg[31:0] : d33[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUTPUT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUTPUT && out_free) begin
      result.left_position  <= left_pos;
      result.right_position <= right_pos;
      result.left_speed     <= f_left;
      result.right_speed    <= f_right;
      result.elapsed_ms     <= dt;
    end
  end

endmodule

@@ src/evs_divider.sv @@
// Restoring divider, one quotient bit per cycle, with overflow detection.
// Depends on evs_pkg.
module evs_divider import evs_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NQ_W-1:0] dividend,
  input  logic [31:0]     divisor,
  output evs_div_res_t    res
);

  logic                 busy;
  logic                 done;
  logic                 sat;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [31:0]          quo;
  logic [32:0]          rem2;
  logic [32:0]          sub;
  logic                 ge;
  logic [HI_W-1:0]      hi;

  assign hi   = dividend[NQ_W-1:32];
  assign rem2 = {rem, quo[31]};
  assign sub  = rem2 - {1'b0, divisor};
  assign ge   = rem2 >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // quotient would not fit 32 bits
      sat <= 64'(hi) >= 64'(divisor);
      rem <= 32'(hi);
      quo <= dividend[31:0];
    end else if (busy) begin
      rem <= ge ? sub[31:0] : rem2[31:0];
      quo <= {quo[30:0], ge};
    end
  end

  assign res.done     = done;
  assign res.sat      = sat;
  assign res.quotient = quo;

endmodule

@@ src/evs_checker.sv @@
// Port-level checks for encoder_velocity_estimator_unit, bound to the top level.
// Depends on evs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module evs_checker import evs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input evs_result_t result,
  input logic        result_valid,
  input logic        result_stall
);

  `ASSERT_IMPLIES(a_elapsed_nonzero, result_valid, result.elapsed_ms != 32'd0)
  `ASSERT_NEXT(a_no_instant_result, sample_valid && !sample_stall, !$rose(result_valid))
  `ASSERT_IMPLIES(a_ready_on_result, $rose(result_valid), !sample_stall)
  `ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind encoder_velocity_estimator_unit evs_checker u_evs_checker (.*);
